// ===== rtl/lcts_pkg.sv =====
// Shared types, constants and helpers for the load cell tare and smoothing block.
package lcts_pkg;

   localparam int COUNT_W  = 24;
   localparam int WEIGHT_W = 32;
   localparam int GAIN_SHIFT = 16;
   // product of two 25-bit signed operands
   localparam int PROD_W = 2 * (COUNT_W + 1);
   // weight after the gain shift, before saturation
   localparam int WIDE_W = PROD_W - GAIN_SHIFT;
   localparam int CAL_SAMPLES_DEF = 20;

   localparam logic [COUNT_W-1:0] SIGN_FLIP       = 24'h800000;
   localparam logic [COUNT_W-1:0] WINDOW_LOW_RST  = 24'd6900000;
   localparam logic [COUNT_W-1:0] WINDOW_HIGH_RST = 24'd8100000;
   localparam logic [COUNT_W-1:0] CAL_GAIN_RST    = 24'd65536;
   // 2.0 in Q23.8
   localparam int TWO_Q8 = 512;

   typedef enum logic [1:0] {
      REG_WINDOW_LOW  = 2'd0,
      REG_WINDOW_HIGH = 2'd1,
      REG_CAL_GAIN    = 2'd2
   } reg_index_type;

   function automatic logic signed [WEIGHT_W-1:0] sat_q32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] max_v;
      logic signed [WIDE_W-1:0] min_v;
      logic signed [WEIGHT_W-1:0] res;
      max_v = WIDE_W'(64'sd2147483647);
      min_v = WIDE_W'(-64'sd2147483648);
      if (v > max_v) begin
         res = 32'sh7FFFFFFF;
      end else if (v < min_v) begin
         res = 32'sh80000000;
      end else begin
         res = $signed(v[WEIGHT_W-1:0]);
      end
      return res;
   endfunction

endpackage

// ===== rtl/lcts_tare.sv =====
// Tare sequencer: flush, window-gated averaging and the reciprocal offset divide.
module lcts_tare #(
   parameter int CAL_SAMPLES = lcts_pkg::CAL_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [lcts_pkg::COUNT_W-1:0] count,
   input  logic [lcts_pkg::COUNT_W-1:0] window_low,
   input  logic [lcts_pkg::COUNT_W-1:0] window_high,
   output logic                         done,
   output logic [lcts_pkg::COUNT_W-1:0] offset
);
   import lcts_pkg::*;

   localparam int AccW  = $clog2(CAL_SAMPLES + 1);
   localparam int SumW  = COUNT_W + AccW;
   // floor(sum / CAL_SAMPLES) as a multiply by the rounded-up reciprocal, exact for any sum
   localparam int RecipShift = SumW + $clog2(CAL_SAMPLES);
   localparam int RecipW     = SumW + 2;
   localparam int ProdW      = SumW + RecipW;
   localparam logic [AccW-1:0]   AccLast = AccW'(CAL_SAMPLES - 1);
   localparam logic [RecipW-1:0] Recip   =
      RecipW'(((64'd1 << RecipShift) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

   logic               flush_ff, flush_in;
   logic [AccW-1:0]    acc_ff, acc_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] offset_ff, offset_in;

   logic               in_win;
   logic [ProdW-1:0]   quot_prod;

   assign in_win    = (count > window_low) && (count < window_high);
   assign quot_prod = ProdW'(sum_ff) * ProdW'(Recip);
   assign offset_in = quot_prod[RecipShift +: COUNT_W];

   always_comb begin
      flush_in = flush_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      done_in  = done_ff;
      if (take) begin
         if (!flush_ff) begin
            flush_in = 1'b1;
         end else if (!done_ff && in_win) begin
            sum_in = sum_ff + SumW'(count);
            acc_in = acc_ff + 1'b1;
            if (acc_ff == AccLast) begin
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff  <= 1'b0;
         acc_ff    <= '0;
         sum_ff    <= '0;
         done_ff   <= 1'b0;
         offset_ff <= '0;
      end else begin
         flush_ff  <= flush_in;
         acc_ff    <= acc_in;
         sum_ff    <= sum_in;
         done_ff   <= done_in;
         // the sum freezes once done, so the offset is final from the cycle after done rises
         offset_ff <= offset_in;
      end
   end

   assign done   = done_ff;
   assign offset = offset_ff;

endmodule

// ===== rtl/lcts_filt.sv =====
// Weight pipeline: input register, gain multiply, jump-limited smoothing, result register.
module lcts_filt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic                                 filt,
   input  logic [lcts_pkg::COUNT_W-1:0]         count,
   input  logic [lcts_pkg::COUNT_W-1:0]         offset,
   input  logic [lcts_pkg::COUNT_W-1:0]         gain,
   input  logic                                 rsp_stall,
   output logic                                 adv,
   output logic                                 rsp_valid,
   output logic signed [lcts_pkg::WEIGHT_W-1:0] rsp_filtered_weight,
   output logic                                 rsp_tare_done
);
   import lcts_pkg::*;

   logic                      v1_ff, f1_ff;
   logic [COUNT_W-1:0]        cnt1_ff;
   logic                      v2_ff, f2_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [COUNT_W:0]   diff;

   logic                      rsp_valid_ff;
   logic signed [WEIGHT_W-1:0] rsp_fw_ff, rsp_fw_in;
   logic                      rsp_td_ff;
   logic signed [WEIGHT_W-1:0] smooth_ff, smooth_in;

   logic signed [WIDE_W-1:0]   wide_w;
   logic signed [WEIGHT_W-1:0] weight;
   logic signed [WEIGHT_W:0]   wx, sx;
   logic [WEIGHT_W:0]          mag_w, mag_s;
   logic [WIDE_W-1:0]          lim;
   logic [WIDE_W-1:0]          bound;
   logic                       jump;
   logic signed [WIDE_W-1:0]   sum3;
   logic signed [WEIGHT_W-1:0] step_v, blend_v;

   // advance the whole pipe whenever the result register can take a word
   assign adv = !rsp_valid_ff || !rsp_stall;

   assign diff    = $signed({1'b0, cnt1_ff}) - $signed({1'b0, offset});
   assign prod_in = PROD_W'(diff * $signed({1'b0, gain}));

   assign wide_w = prod_ff[PROD_W-1:GAIN_SHIFT];
   assign weight = sat_q32(wide_w);

   assign wx    = (WEIGHT_W + 1)'(weight);
   assign sx    = (WEIGHT_W + 1)'(smooth_ff);
   assign mag_w = wx[WEIGHT_W] ? $unsigned(-wx) : $unsigned(wx);
   assign mag_s = sx[WEIGHT_W] ? $unsigned(-sx) : $unsigned(sx);
   assign lim   = WIDE_W'(mag_s) + WIDE_W'(TWO_Q8);
   assign bound = {lim[WIDE_W-2:0], 1'b0};
   assign jump  = WIDE_W'(mag_w) > bound;

   assign step_v  = sat_q32(WIDE_W'(smooth_ff) + WIDE_W'(TWO_Q8));
   assign sum3    = (WIDE_W'(smooth_ff) <<< 1) + WIDE_W'(smooth_ff) + WIDE_W'(weight);
   assign blend_v = sat_q32(sum3 >>> 2);

   always_comb begin
      smooth_in = smooth_ff;
      rsp_fw_in = '0;
      if (v2_ff && f2_ff) begin
         smooth_in = jump ? step_v : blend_v;
         rsp_fw_in = smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         smooth_ff    <= '0;
      end else if (adv) begin
         v1_ff        <= take;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
         smooth_ff    <= smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff     <= filt;
         cnt1_ff   <= count;
         f2_ff     <= f1_ff;
         prod_ff   <= prod_in;
         rsp_fw_ff <= rsp_fw_in;
         rsp_td_ff <= f2_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_weight = rsp_fw_ff;
   assign rsp_tare_done       = rsp_td_ff;

endmodule

// ===== rtl/load_cell_tare_and_smoothing.sv =====
// Load cell tare and smoothing top level: register file, tare sequencer, weight pipeline.
// The rsp word for an accepted req word passes the input, product and result registers.
// Throughput: one word per cycle sustained; req stalls only while a valid rsp word is stalled.
// Reset (synchronous, active high) restores the window and gain registers, clears the tare
// state and the filter, and keeps the first word after it out of the tare average.
module load_cell_tare_and_smoothing #(
   parameter int CAL_SAMPLES = lcts_pkg::CAL_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lcts_pkg::COUNT_W-1:0]         req_raw_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lcts_pkg::WEIGHT_W-1:0] rsp_filtered_weight,
   output logic                                 rsp_tare_done,
   input  logic                                 csr_write,
   input  logic [1:0]                           csr_index,
   input  logic [lcts_pkg::COUNT_W-1:0]         csr_wdata
);
   import lcts_pkg::*;

   logic [COUNT_W-1:0] window_low_ff, window_high_ff, cal_gain_ff;
   logic [COUNT_W-1:0] count;
   logic [COUNT_W-1:0] offset;
   logic               done;
   logic               adv;
   logic               take;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= WINDOW_LOW_RST;
         window_high_ff <= WINDOW_HIGH_RST;
         cal_gain_ff    <= CAL_GAIN_RST;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_WINDOW_LOW:  window_low_ff  <= csr_wdata;
            REG_WINDOW_HIGH: window_high_ff <= csr_wdata;
            REG_CAL_GAIN:    cal_gain_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold req while the pipe is blocked
   assign req_stall = !adv;
   assign take      = req_valid && !req_stall;
   assign count     = req_raw_code ^ SIGN_FLIP;

   lcts_tare #(
      .CAL_SAMPLES(CAL_SAMPLES)
   ) u_tare (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .count       (count),
      .window_low  (window_low_ff),
      .window_high (window_high_ff),
      .done        (done),
      .offset      (offset)
   );

   lcts_filt u_filt (
      .clock               (clock),
      .reset               (reset),
      .take                (take),
      .filt                (done),
      .count               (count),
      .offset              (offset),
      .gain                (cal_gain_ff),
      .rsp_stall           (rsp_stall),
      .adv                 (adv),
      .rsp_valid           (rsp_valid),
      .rsp_filtered_weight (rsp_filtered_weight),
      .rsp_tare_done       (rsp_tare_done)
   );

endmodule

// ===== tb/load_cell_tare_and_smoothing_checker.sv =====
// Checker for the load cell tare and smoothing block: predicts every rsp word and compares it.
module load_cell_tare_and_smoothing_checker #(
   parameter int CAL_SAMPLES = lcts_pkg::CAL_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [lcts_pkg::COUNT_W-1:0]         req_raw_code,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [lcts_pkg::WEIGHT_W-1:0] rsp_filtered_weight,
   input  logic                                 rsp_tare_done,
   input  logic                                 csr_write,
   input  logic [1:0]                           csr_index,
   input  logic [lcts_pkg::COUNT_W-1:0]         csr_wdata,
   output int                                   fail_count,
   output int                                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lcts_pkg::*;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic                       done;
   } scale_word_type;

   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   logic [COUNT_W-1:0]         win_lo;
   logic [COUNT_W-1:0]         win_hi;
   logic [COUNT_W-1:0]         gain;
   logic                       primed;
   logic [4:0]                 tare_n;
   logic [28:0]                tare_acc;
   logic [COUNT_W-1:0]         zero_offset;
   logic signed [WEIGHT_W-1:0] level;
   scale_word_type             weight_q[$];
   int                         mismatches = 0;

   function automatic logic signed [WEIGHT_W-1:0] clamp32(input longint v);
      if (v > MAX32) begin
         return 32'sh7FFFFFFF;
      end
      if (v < MIN32) begin
         return 32'sh80000000;
      end
      return v[WEIGHT_W-1:0];
   endfunction

   // Advance the tare and filter state by one raw code and return the word it yields.
   function automatic scale_word_type weigh_sample(input logic [COUNT_W-1:0] raw);
      logic [COUNT_W-1:0] cnt;
      longint             diff;
      longint             w;
      longint             s;
      longint             mag_w;
      longint             mag_s;
      scale_word_type     r;
      cnt = raw ^ SIGN_FLIP;
      r = '0;
      if (!primed) begin
         primed = 1'b1;
      end else if (tare_n < CAL_SAMPLES) begin
         if (cnt > win_lo && cnt < win_hi) begin
            tare_acc = tare_acc + cnt;
            tare_n = tare_n + 5'd1;
            if (tare_n == CAL_SAMPLES) begin
               zero_offset = COUNT_W'(tare_acc / CAL_SAMPLES);
            end
         end
      end else begin
         diff = longint'(cnt) - longint'(zero_offset);
         w = longint'(clamp32((diff * longint'(gain)) >>> GAIN_SHIFT));
         s = longint'(level);
         mag_w = (w < 0) ? -w : w;
         mag_s = (s < 0) ? -s : s;
         // reject the jump: creep up by 2.0 only
         if (mag_w > 2 * (mag_s + TWO_Q8)) begin
            level = clamp32(s + TWO_Q8);
         end else begin
            level = clamp32((3 * s + w) >>> 2);
         end
         r.weight = level;
         r.done = 1'b1;
      end
      return r;
   endfunction

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin : watch
      scale_word_type want;
      if (reset) begin
         win_lo = WINDOW_LOW_RST;
         win_hi = WINDOW_HIGH_RST;
         gain = CAL_GAIN_RST;
         primed = 1'b0;
         tare_n = '0;
         tare_acc = '0;
         zero_offset = '0;
         level = '0;
         weight_q.delete();
      end else begin
         // compare before queueing so a word with nothing ahead of it is caught
         if (rsp_valid && !rsp_stall) begin
            if (weight_q.size() == 0) begin
               flag($sformatf("unexpected word: weight %0d tare_done %0b",
                              rsp_filtered_weight, rsp_tare_done));
            end else begin
               want = weight_q.pop_front();
               if (rsp_filtered_weight !== want.weight) begin
                  flag($sformatf("filtered_weight expected %0d got %0d",
                                 want.weight, rsp_filtered_weight));
               end
               if (rsp_tare_done !== want.done) begin
                  flag($sformatf("tare_done expected %0b got %0b",
                                 want.done, rsp_tare_done));
               end
            end
         end
         if (req_valid && !req_stall) begin
            weight_q.push_back(weigh_sample(req_raw_code));
         end
         if (csr_write) begin
            case (csr_index)
               REG_WINDOW_LOW:  win_lo = csr_wdata;
               REG_WINDOW_HIGH: win_hi = csr_wdata;
               REG_CAL_GAIN:    gain = csr_wdata;
               default: ;
            endcase
         end
      end
      pending <= weight_q.size();
      fail_count <= mismatches;
   end

endmodule

// ===== tb/load_cell_tare_and_smoothing_tb.sv =====
// Testbench top for the load cell tare and smoothing block: stimulus, idling and verdict.
module load_cell_tare_and_smoothing_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lcts_pkg::*;

   localparam int          CAL_N     = CAL_SAMPLES_DEF;
   localparam int          SETTLE    = 40;
   localparam int          END_WAIT  = 10;
   localparam int          LIMIT     = 200000;
   localparam logic [1:0]  REG_SPARE = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [COUNT_W-1:0]         req_raw_code = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [WEIGHT_W-1:0] rsp_filtered_weight;
   logic                       rsp_tare_done;
   logic                       csr_write = 1'b0;
   logic [1:0]                 csr_index = REG_WINDOW_LOW;
   logic [COUNT_W-1:0]         csr_wdata = '0;

   int fail_count;
   int pending;

   // stimulus-side bookkeeping
   int                         words_sent = 0;
   int                         words_seen = 0;
   int                         stall_left = 0;
   int                         cycles = 0;
   bit                         calm = 1'b0;
   logic signed [WEIGHT_W-1:0] last_level = '0;
   logic [COUNT_W-1:0]         lo_now = WINDOW_LOW_RST;
   logic [COUNT_W-1:0]         hi_now = WINDOW_HIGH_RST;
   logic [COUNT_W-1:0]         gain_now = CAL_GAIN_RST;
   bit                         flushed = 1'b0;
   int                         tare_hits = 0;
   logic [28:0]                tare_total = '0;
   logic [COUNT_W-1:0]         est_offset = '0;

   load_cell_tare_and_smoothing i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_code        (req_raw_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_weight (rsp_filtered_weight),
      .rsp_tare_done       (rsp_tare_done),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   load_cell_tare_and_smoothing_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_code        (req_raw_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_weight (rsp_filtered_weight),
      .rsp_tare_done       (rsp_tare_done),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("load_cell_tare_and_smoothing verification failed");
         $finish;
      end
   end

   // Mostly short idles, now and then a long one; none at all while calm.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(99);
      if (calm || r < 70) begin
         return 0;
      end
      if (r < 95) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 10);
   endfunction

   always @(posedge clock) begin : stall_gen
      int n;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         n = pick_idle();
         rsp_stall <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         words_seen <= words_seen + 1;
         last_level <= rsp_filtered_weight;
      end
   end

   task automatic send_word(input logic [COUNT_W-1:0] raw);
      int                 gap;
      logic [COUNT_W-1:0] cnt;
      gap = pick_idle();
      csr_write <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_code <= raw;
      do @(posedge clock); while (req_stall);
      words_sent++;
      // track the tare so later codes can be placed around the offset
      cnt = raw ^ SIGN_FLIP;
      if (!flushed) begin
         flushed = 1'b1;
      end else if (tare_hits < CAL_N && cnt > lo_now && cnt < hi_now) begin
         tare_total = tare_total + cnt;
         tare_hits++;
         if (tare_hits == CAL_N) begin
            est_offset = COUNT_W'(tare_total / CAL_N);
         end
      end
   endtask

   task automatic send_count(input longint c);
      if (c < 0) begin
         c = 0;
      end else if (c > 16777215) begin
         c = 16777215;
      end
      send_word(c[COUNT_W-1:0] ^ SIGN_FLIP);
   endtask

   task automatic drain();
      if (words_seen != words_sent) begin
         req_valid <= 1'b0;
         while (words_seen != words_sent) @(posedge clock);
      end
   endtask

   // Drain, then idle a while before touching registers.
   task automatic settle();
      drain();
      csr_write <= 1'b0;
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [COUNT_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_WINDOW_LOW:  lo_now = val;
         REG_WINDOW_HIGH: hi_now = val;
         REG_CAL_GAIN:    gain_now = val;
         default: ;
      endcase
   endtask

   // Place the next weight right at the reject threshold of the current level, or one past it.
   task automatic track_level(input bit rising, input int extra);
      longint s;
      longint t;
      longint d;
      drain();
      s = longint'(last_level);
      t = 2 * (((s < 0) ? -s : s) + TWO_Q8);
      d = (t * 65536) / longint'(gain_now) + extra;
      if (!rising) begin
         d = -d;
      end
      send_count(longint'(est_offset) + d);
   endtask

   task automatic send_edge_code();
      case ($urandom_range(3))
         0: send_word(24'h000000);
         1: send_word(24'hFFFFFF);
         2: send_word(24'h800000);
         default: send_word(24'h7FFFFF);
      endcase
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] lo;
      int                 r;
      logic [COUNT_W-1:0] gains [5];

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty window at the extremes: nothing may be accepted
      settle();
      write_reg(REG_WINDOW_LOW, 24'hFFFFFF);
      write_reg(REG_WINDOW_HIGH, 24'h000000);
      write_reg(REG_SPARE, 24'($urandom));
      send_word(24'($urandom));
      send_word(24'h000000);
      send_word(24'hFFFFFF);
      send_word(24'h800000);
      send_word(24'h7FFFFF);

      // low one below high still leaves the window empty
      settle();
      write_reg(REG_WINDOW_LOW, 24'd5000);
      write_reg(REG_WINDOW_HIGH, 24'd5001);
      send_count(5000);
      send_count(5001);

      // widest window: only the outermost counts are refused
      settle();
      write_reg(REG_WINDOW_LOW, 24'h000000);
      write_reg(REG_WINDOW_HIGH, 24'hFFFFFF);
      send_count(0);
      send_count(1);
      send_count(16777214);
      send_count(16777215);

      settle();
      write_reg(REG_WINDOW_LOW, WINDOW_LOW_RST);
      write_reg(REG_WINDOW_HIGH, WINDOW_HIGH_RST);
      send_count(longint'(WINDOW_LOW_RST));
      send_count(longint'(WINDOW_LOW_RST) + 1);
      send_count(longint'(WINDOW_HIGH_RST) - 1);
      send_count(longint'(WINDOW_HIGH_RST));

      // finish the tare high so that a zero count saturates the weight negative
      settle();
      lo = 24'($urandom_range(9500000, 8500000));
      write_reg(REG_WINDOW_LOW, lo);
      write_reg(REG_WINDOW_HIGH, lo + 24'($urandom_range(4000000, 1000000)));
      while (tare_hits < CAL_N) begin
         if ($urandom_range(3) != 0) begin
            send_count(longint'($urandom_range(hi_now - 1, lo_now + 1)));
         end else begin
            send_word(24'($urandom));
         end
      end

      // reject threshold: equal stays smoothed, one past steps up
      settle();
      write_reg(REG_CAL_GAIN, CAL_GAIN_RST);
      for (int k = 0; k < 12; k++) begin
         track_level(k[1], int'(k[0]));
      end

      // climb toward full scale, then fall to the negative limit
      settle();
      write_reg(REG_CAL_GAIN, 24'hFFFFFF);
      repeat (80) track_level(1'b1, 0);
      repeat (110) track_level(1'b0, 0);

      gains[0] = 24'h000000;
      gains[1] = 24'h000001;
      gains[2] = 24'hFFFFFF;
      gains[3] = 24'($urandom_range(24'hFFFFFF, 1));
      gains[4] = 24'($urandom_range(200000, 256));
      for (int p = 0; p < 5; p++) begin
         settle();
         calm = (p == 2);
         write_reg(REG_CAL_GAIN, gains[p]);
         if (p == 3) begin
            write_reg(REG_WINDOW_LOW, 24'($urandom));
            write_reg(REG_WINDOW_HIGH, 24'($urandom));
         end
         repeat (45) begin
            r = $urandom_range(99);
            if (r < 35 || (r < 55 && gain_now == 0)) begin
               send_count(longint'(est_offset) + longint'($urandom_range(4094)) - 2047);
            end else if (r < 55) begin
               track_level(1'($urandom_range(1)), int'($urandom_range(1)));
            end else if (r < 90) begin
               send_word(24'($urandom));
            end else begin
               send_edge_code();
            end
         end
      end
      calm = 1'b0;

      drain();
      repeat (END_WAIT) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("load_cell_tare_and_smoothing verification clean");
      end else begin
         $display("load_cell_tare_and_smoothing verification failed");
      end
      $finish;
   end

endmodule

// ===== load_cell_tare_and_smoothing.f =====
rtl/lcts_pkg.sv
rtl/lcts_tare.sv
rtl/lcts_filt.sv
rtl/load_cell_tare_and_smoothing.sv
tb/load_cell_tare_and_smoothing_checker.sv
tb/load_cell_tare_and_smoothing_tb.sv
